// ===== rtl/barrel_pump_sequencer_assert.svh =====
// Assertion macros for the pump sequencer RTL.
// BPS_ASSERT checks a property on clk with reset masking it.
// BPS_ASSERT_NR checks a property on clk at every edge, reset included.
`ifndef BARREL_PUMP_SEQUENCER_ASSERT_SVH
`define BARREL_PUMP_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define BPS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define BPS_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");
`else
`define BPS_ASSERT(label, clk, rst, prop)
`define BPS_ASSERT_NR(label, clk, prop)
`endif

`endif

// ===== rtl/bps_pkg.sv =====
package bps_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_STABLE_SAMPLES = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE_LIMIT = 2'd1;
  localparam logic [1:0] REG_PHASE_DELAY    = 2'd2;

  localparam logic [7:0] STABLE_SAMPLES_RST = 8'd10;
  localparam logic [7:0] DEBOUNCE_LIMIT_RST = 8'd10;
  localparam logic [7:0] PHASE_DELAY_RST    = 8'd20;

  localparam int NUM_SENSE = 4;

  // port bit of each qualified input, in flag order: upper, lower, main, key
  localparam logic [2:0] SENSE_BIT [NUM_SENSE] = '{3'd5, 3'd0, 3'd6, 3'd2};

  typedef struct packed {
    logic [7:0] stable_samples;
    logic [7:0] debounce_limit;
    logic [7:0] phase_delay;
  } bps_cfg_t;

  // qualified flags; upper sits in bit 0
  typedef struct packed {
    logic key;
    logic main;
    logic lower;
    logic upper;
  } bps_flags_t;

endpackage

// ===== rtl/bps_cond.sv =====
`include "barrel_pump_sequencer_assert.svh"

// Input conditioning: stability filter on the raw port, then integrating
// debouncers on the four sensed bits. flags_next is the result of the
// current sample and is valid in the cycle of the transfer.
module bps_cond
  import bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] port_sample,
  input  bps_cfg_t   cfg,
  output bps_flags_t flags_next
);

  logic [7:0]           last_sample;
  logic [7:0]           repeat_count;
  logic [7:0]           filtered_word;
  logic [7:0]           counts [NUM_SENSE];
  logic [NUM_SENSE-1:0] flags;

  logic [7:0]           repeat_count_next;
  logic [7:0]           filtered_word_next;
  logic [7:0]           counts_next [NUM_SENSE];
  logic [NUM_SENSE-1:0] flags_vec_next;
  logic [NUM_SENSE-1:0] count_zero;

  always_comb begin
    logic [7:0] rc_inc;
    rc_inc             = repeat_count + 8'd1;
    repeat_count_next  = repeat_count;
    filtered_word_next = filtered_word;
    if (port_sample == last_sample) begin
      if (repeat_count < cfg.stable_samples) begin
        repeat_count_next = rc_inc;
        if (rc_inc >= cfg.stable_samples) begin
          filtered_word_next = last_sample;
        end
      end
    end else begin
      repeat_count_next = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SENSE; i++) begin
      counts_next[i]    = counts[i];
      flags_vec_next[i] = flags[i];
      if (!filtered_word_next[SENSE_BIT[i]]) begin
        if (counts[i] < cfg.debounce_limit) begin
          counts_next[i] = counts[i] + 8'd1;
          if (counts_next[i] == cfg.debounce_limit) begin
            flags_vec_next[i] = 1'b1;
          end
        end
      end else if (counts[i] != 8'd0) begin
        counts_next[i] = counts[i] - 8'd1;
        if (counts_next[i] == 8'd0) begin
          flags_vec_next[i] = 1'b0;
        end
      end
      count_zero[i] = (counts[i] == 8'd0);
    end
  end

  assign flags_next = bps_flags_t'(flags_vec_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample   <= '0;
      repeat_count  <= '0;
      filtered_word <= '0;
      flags         <= '0;
      for (int i = 0; i < NUM_SENSE; i++) begin
        counts[i] <= '0;
      end
    end else if (advance) begin
      last_sample   <= port_sample;
      repeat_count  <= repeat_count_next;
      filtered_word <= filtered_word_next;
      flags         <= flags_vec_next;
      for (int i = 0; i < NUM_SENSE; i++) begin
        counts[i] <= counts_next[i];
      end
    end
  end

  // a set flag always has a nonzero integrator behind it
  `BPS_ASSERT(a_flag_has_count, clk, rst, (flags & count_zero) == '0)
  `BPS_ASSERT(a_filter_copies_last, clk, rst,
              !$past(rst) && !$stable(filtered_word) |-> filtered_word == $past(last_sample))
  `BPS_ASSERT(a_upper_sets_at_limit, clk, rst,
              !$past(rst) && flags[0] && !$past(flags[0]) |-> counts[0] == cfg.debounce_limit)

endmodule

// ===== rtl/barrel_pump_sequencer.sv =====
`include "barrel_pump_sequencer_assert.svh"

// Pump sequencer with filtered, debounced sensor inputs. Each transfer on the
// slave side carries one active-low port sample (tdata) and a control tick
// (tuser); each one yields exactly one result on the master side: the
// inverted drive byte, the qualified upper and lower level flags and the
// sequencer phase. A sample is taken every clock cycle when the result
// register is free or being drained; a single register stage holds the
// filter, debounce and sequencer state. The sequencer only steps on items
// whose tick is set; other items repeat the last drive byte. Configuration
// writes (index 0 stable samples, 1 debounce limit, 2 phase delay, 3 ignored)
// are always ready and belong in idle time.
module barrel_pump_sequencer
  import bps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] port_sample
  input  logic [0:0]  s_tuser,   // [0] control_tick
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] drive_port, [8] upper_level, [9] lower_level,
                                 // [13:10] phase, [15:14] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam logic [3:0] PH_OFF    = 4'd0;
  localparam logic [3:0] PH_UP1    = 4'd1;
  localparam logic [3:0] PH_UP2    = 4'd2;
  localparam logic [3:0] PH_DOWN1  = 4'd3;
  localparam logic [3:0] PH_DOWN2  = 4'd4;
  localparam logic [3:0] PH_UP1M   = 4'd5;
  localparam logic [3:0] PH_UP2M   = 4'd6;
  localparam logic [3:0] PH_DOWN1M = 4'd7;
  localparam logic [3:0] PH_DOWN2M = 4'd8;

  localparam logic [7:0] DRV_PUMP1 = 8'h01;
  localparam logic [7:0] DRV_PUMP2 = 8'h02;
  localparam logic [7:0] DRV_LAMP  = 8'h40;
  localparam logic [7:0] DRV_VALVE = 8'h80;

  bps_cfg_t   cfg;
  bps_flags_t flags_next;
  logic       advance;
  logic       tick;

  logic [3:0] state;
  logic [7:0] phase_counter;
  logic [7:0] drive;
  logic [3:0] state_next;
  logic [7:0] phase_counter_next;
  logic [7:0] drive_next;
  logic       upper_out;
  logic       lower_out;

  assign s_tready  = !m_tvalid || m_tready;
  assign advance   = s_tvalid && s_tready;
  assign tick      = s_tuser[0];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stable_samples <= STABLE_SAMPLES_RST;
      cfg.debounce_limit <= DEBOUNCE_LIMIT_RST;
      cfg.phase_delay    <= PHASE_DELAY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STABLE_SAMPLES: cfg.stable_samples <= cfg_data;
        REG_DEBOUNCE_LIMIT: cfg.debounce_limit <= cfg_data;
        REG_PHASE_DELAY:    cfg.phase_delay    <= cfg_data;
        default: ;
      endcase
    end
  end

  bps_cond u_cond (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .port_sample(s_tdata),
    .cfg        (cfg),
    .flags_next (flags_next)
  );

  always_comb begin
    logic [7:0] dec;
    logic [7:0] wind;
    logic [7:0] d;
    logic       up;
    logic       low;
    dec  = phase_counter - 8'd1;
    // wind-down reloads an exhausted counter before counting
    wind = ((phase_counter == 8'd0) ? cfg.phase_delay : phase_counter) - 8'd1;
    up   = flags_next.upper;
    low  = flags_next.lower;
    d    = '0;
    state_next         = state;
    phase_counter_next = phase_counter;
    if (!flags_next.main) begin
      case (state)
        PH_OFF: begin
          if (!up && !low) begin
            state_next         = PH_DOWN1;
            phase_counter_next = cfg.phase_delay;
          end else if (up && low) begin
            state_next         = PH_UP1;
            phase_counter_next = cfg.phase_delay;
          end
        end
        PH_UP1: begin
          d = DRV_PUMP1;
          phase_counter_next = dec;
          if (dec == 8'd0) state_next = PH_UP2;
        end
        PH_UP2: begin
          if (!up && !low) begin
            state_next         = PH_DOWN1;
            phase_counter_next = cfg.phase_delay;
          end
        end
        PH_DOWN1: begin
          d = DRV_PUMP1;
          phase_counter_next = dec;
          if (dec == 8'd0) state_next = PH_DOWN2;
        end
        PH_DOWN2: begin
          d = DRV_PUMP1 | DRV_VALVE;
          if (up && low) begin
            state_next         = PH_UP1;
            phase_counter_next = cfg.phase_delay;
          end
        end
        PH_UP1M, PH_DOWN1M: begin
          d = DRV_PUMP2;
          phase_counter_next = wind;
          if (wind == 8'd0) state_next = PH_OFF;
        end
        PH_DOWN2M: begin
          d = DRV_PUMP2 | DRV_VALVE;
          phase_counter_next = wind;
          if (wind == 8'd0) begin
            state_next         = PH_UP1M;
            phase_counter_next = cfg.phase_delay;
          end
        end
        default: ;
      endcase
      d = d | DRV_LAMP;
    end else begin
      case (state)
        PH_OFF, PH_UP2M: begin
          if (flags_next.key) begin
            state_next         = PH_DOWN1M;
            phase_counter_next = cfg.phase_delay;
          end
        end
        PH_UP1M: begin
          d = DRV_PUMP2;
          phase_counter_next = dec;
          if (dec == 8'd0) state_next = PH_UP2M;
        end
        PH_DOWN1M: begin
          d = DRV_PUMP2;
          phase_counter_next = dec;
          if (dec == 8'd0) state_next = PH_DOWN2M;
        end
        PH_DOWN2M: begin
          d = DRV_PUMP2 | DRV_VALVE;
          if (!flags_next.key) begin
            state_next         = PH_UP1M;
            phase_counter_next = cfg.phase_delay;
          end
        end
        PH_UP1, PH_DOWN1: begin
          d = DRV_PUMP1;
          phase_counter_next = wind;
          if (wind == 8'd0) state_next = PH_OFF;
        end
        PH_DOWN2: begin
          d = DRV_PUMP1 | DRV_VALVE;
          phase_counter_next = wind;
          if (wind == 8'd0) begin
            state_next         = PH_UP1;
            phase_counter_next = cfg.phase_delay;
          end
        end
        default: ;
      endcase
    end
    drive_next = ~d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= PH_OFF;
      phase_counter <= '0;
      drive         <= 8'hFF;
      m_tvalid      <= 1'b0;
    end else begin
      if (advance && tick) begin
        state         <= state_next;
        phase_counter <= phase_counter_next;
        drive         <= drive_next;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // level flags of the result; phase comes straight from state, drive from its own register
  always_ff @(posedge clk) begin
    if (advance) begin
      upper_out <= flags_next.upper;
      lower_out <= flags_next.lower;
    end
  end

  assign m_tdata = {2'b00, state, lower_out, upper_out, drive};

  `BPS_ASSERT(a_phase_in_range, clk, rst, m_tvalid |-> m_tdata[13:10] <= PH_DOWN2M)
  `BPS_ASSERT(a_no_tick_holds_drive, clk, rst,
              advance && !tick |=> $stable(drive) && $stable(state))
  `BPS_ASSERT(a_transfer_gives_result, clk, rst, advance |=> m_tvalid)

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam logic [7:0] DRV_PUMP1 = 8'h01;
  localparam logic [7:0] DRV_PUMP2 = 8'h02;
  localparam logic [7:0] DRV_LAMP  = 8'h40;
  localparam logic [7:0] DRV_VALVE = 8'h80;

  localparam int FLAG_UPPER = 0;
  localparam int FLAG_LOWER = 1;
  localparam int FLAG_MAIN  = 2;
  localparam int FLAG_KEY   = 3;

  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 8;

  typedef enum logic [3:0] {
    PH_OFF, PH_UP1, PH_UP2, PH_DOWN1, PH_DOWN2,
    PH_UP1M, PH_UP2M, PH_DOWN1M, PH_DOWN2M
  } pump_phase_e;

  typedef struct packed {
    logic [3:0] phase;
    logic       lower;
    logic       upper;
    logic [7:0] drive;
  } pump_result_t;

  typedef struct packed {
    logic       tick;
    logic [7:0] sample;
  } sample_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [0:0]  s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_STABLE_SAMPLES;
  logic [7:0]  cfg_data = 8'h00;

  barrel_pump_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's configuration and state
  logic [7:0]  cfg_stable = STABLE_SAMPLES_RST;
  logic [7:0]  cfg_limit  = DEBOUNCE_LIMIT_RST;
  logic [7:0]  cfg_delay  = PHASE_DELAY_RST;
  logic [7:0]  prev_sample = 8'h00;
  logic [7:0]  repeat_cnt = 8'h00;
  logic [7:0]  filt_word = 8'h00;
  logic [7:0]  integ_cnt [NUM_SENSE] = '{default: 8'h00};
  bit          qual [NUM_SENSE] = '{default: 1'b0};
  pump_phase_e pump_phase = PH_OFF;
  logic [7:0]  phase_cnt = 8'h00;
  logic [7:0]  drive_reg = 8'hFF;
  logic [8:0]  phase_seen = '0;

  sample_item_t pending_samples[$];
  pump_result_t expected_results[$];

  int src_idle_pct = 36;
  int sink_idle_pct = 86;
  bit hold_off_req = 1'b0;
  bit hold_off_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int settings_run = 0;
  int fail_count = 0;
  bit gen_manual = 1'b0;

  function automatic bit tick_down();
    phase_cnt = phase_cnt - 8'd1;
    return phase_cnt == 8'd0;
  endfunction

  // reload an exhausted counter before counting down
  function automatic bit unwind();
    if (phase_cnt == 8'd0) phase_cnt = cfg_delay;
    return tick_down();
  endfunction

  function automatic void start_phase(pump_phase_e p);
    pump_phase = p;
    phase_cnt = cfg_delay;
  endfunction

  function automatic logic [7:0] auto_drive(bit up, bit low);
    logic [7:0] d;
    d = 8'h00;
    case (pump_phase)
      PH_OFF: begin
        if (!up && !low) start_phase(PH_DOWN1);
        if (up && low) start_phase(PH_UP1);
      end
      PH_UP1: begin
        d |= DRV_PUMP1;
        if (tick_down()) pump_phase = PH_UP2;
      end
      PH_UP2: begin
        if (!up && !low) start_phase(PH_DOWN1);
      end
      PH_DOWN1: begin
        d |= DRV_PUMP1;
        if (tick_down()) pump_phase = PH_DOWN2;
      end
      PH_DOWN2: begin
        d |= DRV_PUMP1 | DRV_VALVE;
        if (up && low) start_phase(PH_UP1);
      end
      PH_UP1M, PH_DOWN1M: begin
        d |= DRV_PUMP2;
        if (unwind()) pump_phase = PH_OFF;
      end
      PH_DOWN2M: begin
        d |= DRV_PUMP2 | DRV_VALVE;
        if (unwind()) start_phase(PH_UP1M);
      end
      default: ;
    endcase
    return d | DRV_LAMP;
  endfunction

  function automatic logic [7:0] manual_drive(bit key);
    logic [7:0] d;
    d = 8'h00;
    case (pump_phase)
      PH_OFF: begin
        if (key) start_phase(PH_DOWN1M);
      end
      PH_UP1M: begin
        d |= DRV_PUMP2;
        if (tick_down()) pump_phase = PH_UP2M;
      end
      PH_UP2M: begin
        if (key) start_phase(PH_DOWN1M);
      end
      PH_DOWN1M: begin
        d |= DRV_PUMP2;
        if (tick_down()) pump_phase = PH_DOWN2M;
      end
      PH_DOWN2M: begin
        d |= DRV_PUMP2 | DRV_VALVE;
        if (!key) start_phase(PH_UP1M);
      end
      PH_UP1, PH_DOWN1: begin
        d |= DRV_PUMP1;
        if (unwind()) pump_phase = PH_OFF;
      end
      PH_DOWN2: begin
        d |= DRV_PUMP1 | DRV_VALVE;
        if (unwind()) start_phase(PH_UP1);
      end
      default: ;
    endcase
    return d;
  endfunction

  task automatic advance_pump_model(input sample_item_t it, output pump_result_t res);
    logic [7:0] d;
    bit active;
    if (it.sample == prev_sample) begin
      if (repeat_cnt < cfg_stable) begin
        repeat_cnt = repeat_cnt + 8'd1;
        if (repeat_cnt >= cfg_stable) filt_word = prev_sample;
      end
    end else begin
      repeat_cnt = 8'h00;
    end
    prev_sample = it.sample;

    for (int i = 0; i < NUM_SENSE; i++) begin
      active = (filt_word[SENSE_BIT[i]] == 1'b0);
      if (active) begin
        if (integ_cnt[i] < cfg_limit) begin
          integ_cnt[i] = integ_cnt[i] + 8'd1;
          if (integ_cnt[i] == cfg_limit) qual[i] = 1'b1;
        end
      end else if (integ_cnt[i] != 8'h00) begin
        integ_cnt[i] = integ_cnt[i] - 8'd1;
        if (integ_cnt[i] == 8'h00) qual[i] = 1'b0;
      end
    end

    if (it.tick) begin
      if (!qual[FLAG_MAIN]) d = auto_drive(qual[FLAG_UPPER], qual[FLAG_LOWER]);
      else d = manual_drive(qual[FLAG_KEY]);
      drive_reg = ~d;
    end
    phase_seen[pump_phase] = 1'b1;

    res.drive = drive_reg;
    res.upper = qual[FLAG_UPPER];
    res.lower = qual[FLAG_LOWER];
    res.phase = pump_phase;
  endtask

  // sender: predict on every transfer, then offer the next pending sample
  always @(posedge clk) begin
    sample_item_t it;
    pump_result_t res;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        it.sample = s_tdata;
        it.tick = s_tuser[0];
        advance_pump_model(it, res);
        expected_results.push_back(res);
        samples_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          it = pending_samples.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= it.sample;
          s_tuser <= it.tick;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each result, then pick the next ready level
  always @(posedge clk) begin
    pump_result_t got;
    pump_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = pump_result_t'(m_tdata[13:0]);
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result %h with no sample pending", m_tdata);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result %0d: drive %h/%h upper %b/%b lower %b/%b phase %0d/%0d (exp/got)",
                       results_checked, want.drive, got.drive, want.upper, got.upper,
                       want.lower, got.lower, want.phase, got.phase);
          end
        end
      end
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_off_req && !hold_off_done && s_tvalid) begin
        // long stall so the block fills and pushes back on the sender
        m_tready <= 1'b0;
        hold_left <= HOLD_OFF_CYCLES;
        hold_off_done <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_STABLE_SAMPLES: cfg_stable = val;
      REG_DEBOUNCE_LIMIT: cfg_limit = val;
      REG_PHASE_DELAY:    cfg_delay = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_results.size() != 0 || s_tvalid)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly held port words that steer the sequencer, mixed with short noise
  task automatic queue_phase_items(input int n);
    int made;
    int len;
    sample_item_t it;
    logic [7:0] base;
    bit up_on;
    bit low_on;
    bit key_on;
    bit glitchy;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 99) < 15) begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          it.sample = 8'($urandom);
          it.tick = 1'($urandom_range(0, 1));
          pending_samples.push_back(it);
          made++;
        end
      end else begin
        base = 8'($urandom);
        case ($urandom_range(0, 4))
          0, 1: begin
            up_on = 1'b1;
            low_on = 1'b1;
          end
          2, 3: begin
            up_on = 1'b0;
            low_on = 1'b0;
          end
          default: begin
            up_on = 1'($urandom_range(0, 1));
            low_on = 1'($urandom_range(0, 1));
          end
        endcase
        if ($urandom_range(0, 99) < 20) gen_manual = !gen_manual;
        key_on = 1'($urandom_range(0, 1));
        base[SENSE_BIT[FLAG_UPPER]] = !up_on;
        base[SENSE_BIT[FLAG_LOWER]] = !low_on;
        base[SENSE_BIT[FLAG_MAIN]] = !gen_manual;
        base[SENSE_BIT[FLAG_KEY]] = !key_on;
        len = $urandom_range(1, int'(cfg_stable) + int'(cfg_limit) + int'(cfg_delay) + 4);
        if (len > n - made) len = n - made;
        // glitches would keep a slow filter from ever settling
        glitchy = (cfg_stable < 8'd16);
        repeat (len) begin
          it.sample = (glitchy && $urandom_range(0, 99) < 4) ? 8'($urandom) : base;
          it.tick = ($urandom_range(0, 99) < 60);
          pending_samples.push_back(it);
          made++;
        end
      end
    end
  endtask

  task automatic run_phase(input logic [7:0] st, input logic [7:0] lim, input logic [7:0] dly,
                           input int n, input int src_pct, input int snk_pct);
    write_reg(REG_STABLE_SAMPLES, st);
    write_reg(REG_DEBOUNCE_LIMIT, lim);
    write_reg(REG_PHASE_DELAY, dly);
    src_idle_pct <= src_pct;
    sink_idle_pct <= snk_pct;
    @(negedge clk);
    queue_phase_items(n);
    wait_drained();
    settings_run++;
  endtask

  initial begin
    sample_item_t it;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: all-active word, then all-inactive with a glitch
    @(negedge clk);
    for (int k = 0; k < 12; k++) begin
      it.sample = 8'h00;
      it.tick = (k % 3 != 2);
      pending_samples.push_back(it);
    end
    it.sample = 8'hFF;
    it.tick = 1'b1;
    pending_samples.push_back(it);
    it.sample = 8'h00;
    it.tick = 1'b0;
    pending_samples.push_back(it);
    for (int k = 0; k < 10; k++) begin
      it.sample = 8'hFF;
      it.tick = k[0];
      pending_samples.push_back(it);
    end
    it.sample = 8'h5A;
    it.tick = 1'b1;
    pending_samples.push_back(it);
    wait_drained();
    settings_run++;

    run_phase(8'd1, 8'd1, 8'd1, 200, 36, 86);
    run_phase(8'd2, 8'd3, 8'd4, 200, 36, 86);
    write_reg(REG_UNUSED, 8'($urandom));
    run_phase(8'd3, 8'd2, 8'd2, 200, 86, 36);
    run_phase(8'd255, 8'd255, 8'd255, 300, 86, 36);
    run_phase(8'd0, 8'd0, 8'd0, 100, 86, 36);
    hold_off_req <= 1'b1;
    run_phase(8'd1, 8'd1, 8'd0, 350, 0, 0);
    run_phase(8'd4, 8'd6, 8'd3, 200, 0, 0);

    if (expected_results.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", expected_results.size());
    end
    $display("Covered %0d samples and %0d checked results over %0d settings, %0d register writes",
             samples_sent, results_checked, settings_run, cfg_writes);
    $display("Sequencer phases reached (bit per phase): %b, mismatches %0d",
             phase_seen, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bps_pkg.sv
rtl/bps_cond.sv
rtl/barrel_pump_sequencer.sv
verif/tb.sv
